[rtl/core/ras_pkg.sv]
// package for the row sorter: sizes and shared types
`timescale 1ns / 1ps
package ras_pkg;
  localparam int unsigned RowCapacity = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned QueueDepth = 2;

  // item passed from the front part to the back part
  typedef struct packed {
    logic signed [DataW-1:0] element;
    logic                    row_end;
  } ras_item_t;

  // back part phases
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN
  } ras_state_e;
endpackage

[rtl/core/ras_front.sv]
// front part: input handshake and a short item queue
`timescale 1ns / 1ps
module ras_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [31:0]        s_tdata_i,
  input  logic               s_tlast_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output ras_pkg::ras_item_t q_item_o
);
  import ras_pkg::*;

  ras_item_t  buf_q [QueueDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign s_tready_o = (cnt_q != 2'(QueueDepth));
  assign push       = s_tvalid_i && s_tready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = buf_q[rd_q];

  // queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q].element <= s_tdata_i;
      buf_q[wr_q].row_end <= s_tlast_i;
    end
  end
endmodule

[rtl/core/ras_back.sv]
// back part: insertion chain of cells, then drain of the sorted row
`timescale 1ns / 1ps
module ras_back #(
  parameter int unsigned ROW_CAPACITY = ras_pkg::RowCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  ras_pkg::ras_item_t q_item_i,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [31:0]        m_tdata_o,
  output logic               m_tlast_o,
  output logic               m_tuser_o
);
  import ras_pkg::*;

  localparam int unsigned CntW = $clog2(ROW_CAPACITY + 1);

  logic signed [DataW-1:0] cell_q [ROW_CAPACITY];
  logic signed [DataW-1:0] cell_d [ROW_CAPACITY];
  logic [CntW-1:0]         fill_q, fill_d;
  logic                    ovf_q, ovf_d;
  ras_state_e              state_q, state_d;
  logic                    take, shift, insert;
  logic                    obuf_q, obuf_d;

  // output register
  logic [DataW-1:0] odata_q, odata_d;
  logic             olast_q, olast_d, oovf_q, oovf_d;

  assign q_ready_o  = (state_q == ST_LOAD);
  assign take       = q_valid_i && q_ready_o;
  assign m_tvalid_o = obuf_q;
  assign m_tdata_o  = odata_q;
  assign m_tlast_o  = olast_q;
  assign m_tuser_o  = oovf_q;

  // next state, cell chain and drain control
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    obuf_d  = obuf_q && !m_tready_i;
    odata_d = odata_q;
    olast_d = olast_q;
    oovf_d  = oovf_q;
    shift   = 1'b0;
    insert  = (take && (fill_q < CntW'(ROW_CAPACITY)));
    for (int i = 0; i < ROW_CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
    end
    case (state_q)
      ST_LOAD: begin
        if (take) begin
          if (insert) fill_d = fill_q + 1'b1;
          else ovf_d = 1'b1;
          if (q_item_i.row_end) state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!obuf_d) begin
          shift   = 1'b1;
          obuf_d  = 1'b1;
          odata_d = cell_q[0];
          olast_d = (fill_q == CntW'(1));
          oovf_d  = ovf_q;
          fill_d  = fill_q - 1'b1;
          if (fill_q == CntW'(1)) begin
            state_d = ST_LOAD;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
    // each cell keeps the smaller value, larger ones move one place up
    if (insert) begin
      for (int i = 0; i < ROW_CAPACITY; i++) begin
        if (CntW'(i) < fill_q) begin
          if (cell_q[i] > q_item_i.element) begin
            cell_d[i] = (i == 0) ? q_item_i.element :
              ((cell_q[i-((i > 0) ? 1 : 0)] > q_item_i.element) ?
               cell_q[i-((i > 0) ? 1 : 0)] : q_item_i.element);
          end
        end else if (CntW'(i) == fill_q) begin
          cell_d[i] = (i == 0) ? q_item_i.element :
            ((cell_q[i-((i > 0) ? 1 : 0)] > q_item_i.element) ?
             cell_q[i-((i > 0) ? 1 : 0)] : q_item_i.element);
        end
      end
    end
    // drain pops the smallest cell
    if (shift) begin
      for (int i = 0; i < ROW_CAPACITY - 1; i++) begin
        cell_d[i] = cell_q[i+1];
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      obuf_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      obuf_q  <= obuf_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    olast_q <= olast_d;
    oovf_q  <= oovf_d;
    for (int i = 0; i < ROW_CAPACITY; i++) begin
      cell_q[i] <= cell_d[i];
    end
  end
endmodule

[rtl/core/row_ascending_sorter.sv]
// top level of the row sorter
//
// channel | dir | fields
// s_axis  | in  | tdata = element[31:0], tlast = row_end
// m_axis  | out | tdata = sorted_value[31:0], tlast = final_res, tuser = overflowed
//
// one element is taken per cycle while a row loads into the insertion chain
// a row's n stored elements then drain, one result per cycle when not stalled
// no input is taken by the chain during the drain; the two-entry queue absorbs
// a short burst, and the output register holds under back-pressure
// reset clears queue, fill count, overflow and output valid
`timescale 1ns / 1ps
module row_ascending_sorter #(
  parameter int unsigned ROW_CAPACITY = ras_pkg::RowCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // element[31:0]
  input  logic        s_tlast_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // sorted_value[31:0]
  output logic        m_tlast_o,
  output logic        m_tuser_o    // overflowed
);
  import ras_pkg::*;

  logic      q_valid, q_ready;
  ras_item_t q_item;

  ras_front u_front (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .s_tdata_i, .s_tlast_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  ras_back #(.ROW_CAPACITY(ROW_CAPACITY)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_item_i(q_item), .m_tvalid_o, .m_tready_i, .m_tdata_o, .m_tlast_o,
    .m_tuser_o
  );

`ifndef ASSERT_OFF
  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("output changed under stall");
  // sorted order within a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tready_i && !m_tlast_o ##1 m_tvalid_o |->
      $signed(m_tdata_o) >= $signed($past(m_tdata_o)))
    else $error("row out of order");
`endif
endmodule
